[hw/rtl/window_sum_at_most_limit_assert.svh]
// Assertion macros used by the window sum core.
`ifndef WINDOW_SUM_AT_MOST_LIMIT_ASSERT_SVH
`define WINDOW_SUM_AT_MOST_LIMIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wsl_pkg.sv]
// Shared constants and types of the window sum block.
`timescale 1ns / 1ps
package wsl_pkg;

  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VALUE_W    = 16;
  localparam int LIMIT_W    = 24;
  localparam int TOTAL_W    = 25;
  localparam int LEN_W      = 11;
  localparam int COUNT_W    = 20;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT = CFG_IDX_W'(0);

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } store_wr_t;

endpackage

[hw/rtl/wsl_cfg.sv]
// Configuration register file: holds the window sum limit.
`timescale 1ns / 1ps
module wsl_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wsl_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wsl_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wsl_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [wsl_pkg::LIMIT_W-1:0]        sum_limit
);
  import wsl_pkg::*;

  logic [LIMIT_W-1:0]   limit_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_hit;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_SUM_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (wr_hit) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SUM_LIMIT) begin
      prdata = CFG_DATA_W'(limit_r);
    end
  end

  assign pready    = 1'b1;
  assign sum_limit = limit_r;

endmodule

[hw/rtl/wsl_store.sv]
// Element store: one write port, one registered read port.
`timescale 1ns / 1ps
module wsl_store (
  input  logic                          clk,
  input  wsl_pkg::store_wr_t            wr,
  input  logic [wsl_pkg::ADDR_W-1:0]    rd_addr,
  output logic [wsl_pkg::VALUE_W-1:0]   rd_data
);
  import wsl_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/wsl_core.sv]
// Sequencer and shared add/subtract unit of the sliding window.
`timescale 1ns / 1ps
`include "window_sum_at_most_limit_assert.svh"
module wsl_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wsl_pkg::VALUE_W-1:0]   in_value,
  input  logic                          in_first,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wsl_pkg::LEN_W-1:0]     out_window_length,
  output logic [wsl_pkg::LEN_W-1:0]     out_longest_length,
  output logic [wsl_pkg::COUNT_W-1:0]   out_subarray_count,
  output logic                          out_overflow,
  input  logic [wsl_pkg::LIMIT_W-1:0]   sum_limit,
  output wsl_pkg::store_wr_t            wr,
  output logic [wsl_pkg::ADDR_W-1:0]    rd_addr,
  input  logic [wsl_pkg::VALUE_W-1:0]   rd_data
);
  import wsl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SUB   = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   back_r, back_nxt;
  logic [CNT_W-1:0]   best_r, best_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               ovf_r, ovf_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [LEN_W-1:0]   out_best_r, out_best_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               accept;
  logic [CNT_W-1:0]   back_eff;
  logic [TOTAL_W-1:0] total_eff;
  logic               full;
  logic [TOTAL_W-1:0] alu_a, alu_b, alu_y;
  logic               alu_sub;
  logic               need_pop;
  logic               can_emit;
  logic [CNT_W-1:0]   len;
  logic [CNT_W-1:0]   best_upd;
  logic [COUNT_W:0]   count_sum;
  logic [COUNT_W-1:0] count_upd;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign back_eff  = in_first ? '0 : back_r;
  assign total_eff = in_first ? '0 : total_r;
  assign full      = (back_eff >= CNT_W'(DEPTH));

  // the one add/subtract unit: append in IDLE, pop in SUB
  always_comb begin
    alu_sub = (state_r == ST_SUB);
    alu_a   = alu_sub ? total_r : total_eff;
    alu_b   = alu_sub ? TOTAL_W'(rd_data) : TOTAL_W'(in_value);
    alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  assign wr.en   = accept && !full;
  assign wr.addr = back_eff[ADDR_W-1:0];
  assign wr.data = in_value;
  assign rd_addr = front_r[ADDR_W-1:0];

  assign need_pop  = !ovf_r && (total_r > TOTAL_W'(sum_limit)) && (front_r < back_r);
  assign can_emit  = !out_valid_r || !out_stall;
  assign len       = back_r - front_r;
  assign best_upd  = (len > best_r) ? len : best_r;
  assign count_sum = (COUNT_W+1)'(count_r) + (COUNT_W+1)'(len);
  assign count_upd = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    best_nxt      = best_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_len_nxt   = out_len_r;
    out_best_nxt  = out_best_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ovf_nxt   = full;
          state_nxt = ST_CHECK;
          if (in_first) begin
            front_nxt = '0;
            best_nxt  = '0;
            count_nxt = '0;
          end
          if (!full) begin
            back_nxt  = back_eff + CNT_W'(1);
            total_nxt = alu_y;
          end
        end
      end
      ST_CHECK: begin
        if (need_pop) begin
          state_nxt = ST_SUB;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = LEN_W'(len);
          out_ovf_nxt   = ovf_r;
          if (ovf_r) begin
            out_best_nxt  = LEN_W'(best_r);
            out_count_nxt = count_r;
          end else begin
            best_nxt      = best_upd;
            count_nxt     = count_upd;
            out_best_nxt  = LEN_W'(best_upd);
            out_count_nxt = count_upd;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SUB: begin
        total_nxt = alu_y;
        front_nxt = front_r + CNT_W'(1);
        state_nxt = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      front_r     <= '0;
      back_r      <= '0;
      best_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      best_r      <= best_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_len_r   <= out_len_nxt;
    out_best_r  <= out_best_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_window_length  = out_len_r;
  assign out_longest_length = out_best_r;
  assign out_subarray_count = out_count_r;
  assign out_overflow       = out_ovf_r;

  `WSL_ASSERT_IMPLIES(a_front_le_back, 1'b1, (front_r <= back_r) && (back_r <= CNT_W'(DEPTH)), "window front passed back or back passed depth")
  `WSL_ASSERT_IMPLIES(a_emit_within_limit, (state_r == ST_CHECK) && !need_pop && can_emit && !ovf_r, (total_r <= TOTAL_W'(sum_limit)) || (front_r == back_r), "result emitted with window sum above limit")
  `WSL_ASSERT_NEXT(a_count_monotonic, accept && !in_first, count_r >= $past(count_r), "subarray count dropped without a new array")

endmodule

[hw/rtl/window_sum_at_most_limit.sv]
// Top level: sliding window with sum at most a programmable limit.
// Sequence: an accepted element is appended unless the store is full, then each CHECK either
//   drops the front element (a store read, then a pass through the single add/subtract unit
//   in SUB) or loads the result once the result register is free; the input stalls until then.
// Reset: synchronous on rst_n low; clears window, totals and limit; the element store is
//   not cleared (only entries written in the current array are read), so no clearing pass.
`timescale 1ns / 1ps
module window_sum_at_most_limit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wsl_pkg::VALUE_W-1:0]       in_value,
  input  logic                              in_first,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wsl_pkg::LEN_W-1:0]         out_window_length,
  output logic [wsl_pkg::LEN_W-1:0]         out_longest_length,
  output logic [wsl_pkg::COUNT_W-1:0]       out_subarray_count,
  output logic                              out_overflow,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wsl_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wsl_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wsl_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import wsl_pkg::*;

  logic [LIMIT_W-1:0] sum_limit;
  store_wr_t          store_wr;
  logic [ADDR_W-1:0]  store_rd_addr;
  logic [VALUE_W-1:0] store_rd_data;

  // sum_limit register, byte address 0
  wsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sum_limit (sum_limit)
  );

  // store of array elements, indexed by array position; no write once depth is reached
  wsl_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  // append on accept, then drop from the front while the sum is over the limit
  wsl_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_first           (in_first),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_length  (out_window_length),
    .out_longest_length (out_longest_length),
    .out_subarray_count (out_subarray_count),
    .out_overflow       (out_overflow),
    .sum_limit          (sum_limit),
    .wr                 (store_wr),
    .rd_addr            (store_rd_addr),
    .rd_data            (store_rd_data)
  );

endmodule
